### rtl/rsd_pkg.sv
`default_nettype none
package rsd_pkg;

  // Decoder phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_FLAT   = 5'b00010,
    PH_BASE   = 5'b00100,
    PH_COUNT  = 5'b01000,
    PH_ENTRY  = 5'b10000
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Design codes; DESIGN_UNKNOWN marks anything above block designs
  localparam logic [1:0] DESIGN_FLAT    = 2'd0;
  localparam logic [1:0] DESIGN_UNKNOWN = 2'd3;

  // Field width codes
  localparam logic [1:0] WIDTH_2B = 2'd0;
  localparam logic [1:0] WIDTH_4B = 2'd1;
  localparam logic [1:0] WIDTH_8B = 2'd2;

  // Header word slots (byte position bits 2..1 on the odd byte)
  localparam logic [1:0] HDR_FORMAT = 2'd0;
  localparam logic [1:0] HDR_DESIGN = 2'd1;
  localparam logic [1:0] HDR_COUPLE = 2'd2;
  localparam logic [1:0] HDR_COUNT  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  target_section;
    logic [4:0]  source_section;
    logic [63:0] offset;
    logic [3:0]  reloc_type;
    logic        section_end;
  } result_t;

endpackage
`default_nettype wire

### rtl/rsd_in_stage.sv
`default_nettype none
module rsd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       drain,
  output logic            stage_valid,
  output logic [7:0]      stage_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || drain;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule
`default_nettype wire

### rtl/rsd_decoder.sv
`default_nettype none
module rsd_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  output logic            res_valid,
  output rsd_pkg::result_t res
);

  rsd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] field_r, field_nxt;
  logic [1:0]  width_r, width_nxt;
  logic [1:0]  design_mode_r, design_mode_nxt;
  logic [4:0]  target_r, target_nxt;
  logic [4:0]  source_r, source_nxt;
  logic [15:0] couples_r, couples_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] entries_r, entries_nxt;
  logic        halted_r, halted_nxt;

  logic [15:0] hdr_word;
  logic [63:0] fld_merged;
  logic [2:0]  pos_inc;
  logic [2:0]  need;
  logic        fld_done;
  logic [15:0] couples_dec;
  logic [63:0] entries_dec;
  logic [63:0] delta;
  logic [3:0]  etype;
  logic [63:0] entry_offset;

  assign hdr_word    = field_r[15:0] | ({8'h00, data_byte} << {pos_r[0], 3'b000});
  assign fld_merged  = field_r | ({56'd0, data_byte} << {pos_r, 3'b000});
  assign pos_inc     = pos_r + 3'd1;
  assign couples_dec = couples_r - 16'd1;
  assign entries_dec = entries_r - 64'd1;

  // bytes per field; eight wraps to zero in the 3-bit position count
  always_comb begin
    if (phase_r == rsd_pkg::PH_FLAT) begin
      need = 3'd2;
    end else begin
      case (width_r)
        rsd_pkg::WIDTH_2B: need = 3'd2;
        rsd_pkg::WIDTH_4B: need = 3'd4;
        default:           need = 3'd0;
      endcase
    end
  end
  assign fld_done = (pos_inc == need);

  always_comb begin
    case (width_r)
      rsd_pkg::WIDTH_2B: begin
        delta = {52'd0, fld_merged[11:0]};
        etype = fld_merged[15:12];
      end
      rsd_pkg::WIDTH_4B: begin
        delta = {36'd0, fld_merged[27:0]};
        etype = fld_merged[31:28];
      end
      default: begin
        delta = {4'd0, fld_merged[59:0]};
        etype = fld_merged[63:60];
      end
    endcase
  end
  assign entry_offset = base_r + delta;

  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    field_nxt       = field_r;
    width_nxt       = width_r;
    design_mode_nxt = design_mode_r;
    target_nxt      = target_r;
    source_nxt      = source_r;
    couples_nxt     = couples_r;
    base_nxt        = base_r;
    entries_nxt     = entries_r;
    halted_nxt      = halted_r;
    res_valid       = 1'b0;
    res.kind           = rsd_pkg::KIND_ENTRY;
    res.target_section = target_r;
    res.source_section = source_r;
    res.offset         = 64'd0;
    res.reloc_type     = 4'd0;
    res.section_end    = 1'b0;

    if (step && !halted_r) begin
      if (phase_r == rsd_pkg::PH_HEADER) begin
        pos_nxt = pos_inc;
        if (!pos_r[0]) begin
          field_nxt = {48'd0, hdr_word};
        end else begin
          field_nxt = 64'd0;
          case (pos_r[2:1])
            rsd_pkg::HDR_FORMAT: begin
              width_nxt = (hdr_word == 16'd0) ? rsd_pkg::WIDTH_2B :
                          (hdr_word == 16'd1) ? rsd_pkg::WIDTH_4B : rsd_pkg::WIDTH_8B;
            end
            rsd_pkg::HDR_DESIGN: begin
              design_mode_nxt = (hdr_word <= 16'd2) ? hdr_word[1:0]
                                                    : rsd_pkg::DESIGN_UNKNOWN;
            end
            rsd_pkg::HDR_COUPLE: begin
              target_nxt = hdr_word[4:0];
              source_nxt = hdr_word[9:5];
            end
            rsd_pkg::HDR_COUNT: begin
              couples_nxt = hdr_word;
              if (design_mode_r == rsd_pkg::DESIGN_UNKNOWN) begin
                halted_nxt      = 1'b1;
                res_valid       = 1'b1;
                res.kind        = rsd_pkg::KIND_ERROR;
                res.section_end = 1'b1;
              end else if (hdr_word == 16'd0) begin
                res_valid       = 1'b1;
                res.kind        = rsd_pkg::KIND_EMPTY;
                res.section_end = 1'b1;
              end else begin
                phase_nxt = (design_mode_r == rsd_pkg::DESIGN_FLAT) ? rsd_pkg::PH_FLAT
                                                                     : rsd_pkg::PH_BASE;
              end
            end
            default: ;
          endcase
        end
      end else if (!fld_done) begin
        pos_nxt   = pos_inc;
        field_nxt = fld_merged;
      end else begin
        pos_nxt   = 3'd0;
        field_nxt = 64'd0;
        case (phase_r)
          rsd_pkg::PH_FLAT: begin
            couples_nxt     = couples_dec;
            res_valid       = 1'b1;
            res.offset      = {52'd0, fld_merged[11:0]};
            res.reloc_type  = fld_merged[15:12];
            res.section_end = (couples_dec == 16'd0);
            if (couples_dec == 16'd0) begin
              phase_nxt = rsd_pkg::PH_HEADER;
            end
          end
          rsd_pkg::PH_BASE: begin
            base_nxt  = fld_merged;
            phase_nxt = rsd_pkg::PH_COUNT;
          end
          rsd_pkg::PH_COUNT: begin
            entries_nxt = fld_merged;
            if (fld_merged != 64'd0) begin
              phase_nxt = rsd_pkg::PH_ENTRY;
            end else begin
              couples_nxt = couples_dec;
              if (couples_dec == 16'd0) begin
                phase_nxt       = rsd_pkg::PH_HEADER;
                res_valid       = 1'b1;
                res.kind        = rsd_pkg::KIND_EMPTY;
                res.section_end = 1'b1;
              end else begin
                phase_nxt = rsd_pkg::PH_BASE;
              end
            end
          end
          rsd_pkg::PH_ENTRY: begin
            entries_nxt    = entries_dec;
            res_valid      = 1'b1;
            res.offset     = entry_offset;
            res.reloc_type = etype;
            if (entries_dec == 64'd0) begin
              couples_nxt = couples_dec;
              if (couples_dec == 16'd0) begin
                res.section_end = 1'b1;
                phase_nxt       = rsd_pkg::PH_HEADER;
              end else begin
                phase_nxt = rsd_pkg::PH_BASE;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rsd_pkg::PH_HEADER;
      pos_r         <= 3'd0;
      field_r       <= 64'd0;
      width_r       <= rsd_pkg::WIDTH_2B;
      design_mode_r <= rsd_pkg::DESIGN_FLAT;
      target_r      <= 5'd0;
      source_r      <= 5'd0;
      couples_r     <= 16'd0;
      base_r        <= 64'd0;
      entries_r     <= 64'd0;
      halted_r      <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      field_r       <= field_nxt;
      width_r       <= width_nxt;
      design_mode_r <= design_mode_nxt;
      target_r      <= target_nxt;
      source_r      <= source_nxt;
      couples_r     <= couples_nxt;
      base_r        <= base_nxt;
      entries_r     <= entries_nxt;
      halted_r      <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rsd_out_stage.sv
`default_nettype none
module rsd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic             res_valid,
  input  wire rsd_pkg::result_t res,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rsd_pkg::result_t      out_res
);

  logic             valid_r;
  rsd_pkg::result_t res_r;

  // slot frees when empty or when the held result transfers this cycle
  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

### rtl/relocation_section_decoder_core.sv
// Relocation section decoder.
// Input channel: one section byte per transfer on in_data_byte (valid/ready).
// Output channel: one result per relocation entry, plus an end marker for
// empty sections or empty last blocks, and an error result for an unknown
// design; each result carries kind, section numbers, offset, type and
// section_end (valid/ready).
// A byte taken is held in the input register and its result, if any, goes
// on into the output register. Throughput: one byte per cycle, set by the
// single decode step between the input register and the result register;
// both registers move on in every cycle in which out_ready is high.
// Receiver stall: the held result stays put, one more byte sits in the input
// register, then in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous): the decoder returns to the header phase and
// both stages empty. After an unknown design the block swallows every byte
// without result until the next reset.
`default_nettype none
module relocation_section_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [4:0]       out_target_section,
  output logic [4:0]       out_source_section,
  output logic [63:0]      out_offset,
  output logic [3:0]       out_reloc_type,
  output logic             out_section_end
);

  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             can_load;
  logic             step;
  logic             res_valid;
  rsd_pkg::result_t res;
  rsd_pkg::result_t out_res;

  assign step = stage_valid && can_load;

  rsd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .drain        (step),
    .stage_valid  (stage_valid),
    .stage_byte   (stage_byte)
  );

  rsd_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (stage_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_target_section = out_res.target_section;
  assign out_source_section = out_res.source_section;
  assign out_offset         = out_res.offset;
  assign out_reloc_type     = out_res.reloc_type;
  assign out_section_end    = out_res.section_end;

  // end and error results always close the section and carry no offset
  a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != rsd_pkg::KIND_ENTRY) |->
      (out_section_end && out_offset == 64'd0 && out_reloc_type == 4'd0))
    else $error("end or error result with entry fields set");

  // nothing follows an error result until reset
  a_halt_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_kind == rsd_pkg::KIND_ERROR) |=> !out_valid)
    else $error("result after unknown design error");

  // input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without output stall");

endmodule
`default_nettype wire
